@@ rtl/va2f_pkg.sv @@
// ----------------------------------------------------------------------------
// va2f_pkg
// Shared types, element type codes and lane constants for the vertex
// attribute to float4 unit.
// ----------------------------------------------------------------------------
package va2f_pkg;

  localparam int NUM_LANES  = 4;
  localparam int LANE_DEPTH = 8;
  localparam int PIPE_DEPTH = LANE_DEPTH + 1;

  typedef logic [3:0]  elem_type_t;
  typedef logic [2:0]  comp_count_t;
  typedef logic [63:0] raw_t;
  typedef logic [31:0] f32_t;

  localparam elem_type_t ET_F64  = 4'd0;
  localparam elem_type_t ET_F32  = 4'd1;
  localparam elem_type_t ET_U32S = 4'd2;
  localparam elem_type_t ET_S32S = 4'd3;
  localparam elem_type_t ET_U32N = 4'd4;
  localparam elem_type_t ET_S32N = 4'd5;
  localparam elem_type_t ET_U16S = 4'd6;
  localparam elem_type_t ET_S16S = 4'd7;
  localparam elem_type_t ET_U16N = 4'd8;
  localparam elem_type_t ET_S16N = 4'd9;
  localparam elem_type_t ET_U8S  = 4'd10;
  localparam elem_type_t ET_S8S  = 4'd11;
  localparam elem_type_t ET_U8N  = 4'd12;
  localparam elem_type_t ET_S8N  = 4'd13;

  localparam comp_count_t MAX_COUNT = 3'd4;

  localparam f32_t ZERO_BITS = 32'h0000_0000;
  localparam f32_t ONE_BITS  = 32'h3F80_0000;

endpackage

@@ rtl/va2f_if.sv @@
// ----------------------------------------------------------------------------
// va2f channel interfaces
// Attribute input channel and float4 result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface va2f_attr_if;
  import va2f_pkg::*;

  logic        valid;
  logic        ready;
  elem_type_t  element_type;
  comp_count_t component_count;
  raw_t        raw_c0;
  raw_t        raw_c1;
  raw_t        raw_c2;
  raw_t        raw_c3;

  modport source (
    output valid, element_type, component_count, raw_c0, raw_c1, raw_c2, raw_c3,
    input  ready
  );
  modport sink (
    input  valid, element_type, component_count, raw_c0, raw_c1, raw_c2, raw_c3,
    output ready
  );
endinterface

interface va2f_result_if;
  import va2f_pkg::*;

  logic valid;
  logic ready;
  f32_t out_x;
  f32_t out_y;
  f32_t out_z;
  f32_t out_w;

  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink   (input  valid, out_x, out_y, out_z, out_w, output ready);
endinterface

@@ rtl/vertex_attribute_to_float4_unit.sv @@
// an accepted attribute word passes the lane stages and then the merge stage
// throughput: one word per cycle unless stalled, set by four parallel 8-stage lanes
// the whole pipeline holds while the output word is stalled
// reset: synchronous, clears the stage valid bits only
// ----------------------------------------------------------------------------
// vertex_attribute_to_float4_unit
// Converts one vertex attribute of up to four components to four single
// floats, one lane per component and a merging output stage.
// ----------------------------------------------------------------------------
module vertex_attribute_to_float4_unit (
  input  logic          clk,
  input  logic          rst,
  va2f_attr_if.sink     attr,
  va2f_result_if.source result
);
  import va2f_pkg::*;

  logic [PIPE_DEPTH-1:0] vld;
  logic                  adv;
  logic [NUM_LANES-1:0]  pres [1:LANE_DEPTH];
  logic [NUM_LANES-1:0]  pres_next;
  comp_count_t           cnt_sat;
  f32_t                  lane_res [NUM_LANES];
  raw_t                  raw_in [NUM_LANES];

  assign adv          = !vld[PIPE_DEPTH-1] || result.ready;
  assign attr.ready   = adv;
  assign result.valid = vld[PIPE_DEPTH-1];

  assign cnt_sat = (attr.component_count > MAX_COUNT) ? MAX_COUNT : attr.component_count;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      pres_next[i] = (attr.element_type <= ET_S8N) && (3'(i) < cnt_sat);
    end
  end

  assign raw_in[0] = attr.raw_c0;
  assign raw_in[1] = attr.raw_c1;
  assign raw_in[2] = attr.raw_c2;
  assign raw_in[3] = attr.raw_c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], attr.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pres[1] <= pres_next;
      for (int s = 2; s <= LANE_DEPTH; s++) pres[s] <= pres[s-1];
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    va2f_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .etype  (attr.element_type),
      .raw    (raw_in[i]),
      .result (lane_res[i])
    );
  end

  va2f_merge u_merge (
    .clk      (clk),
    .adv      (adv),
    .present  (pres[LANE_DEPTH]),
    .lane_res (lane_res),
    .out_x    (result.out_x),
    .out_y    (result.out_y),
    .out_z    (result.out_z),
    .out_w    (result.out_w)
  );

endmodule

@@ rtl/va2f_lane.sv @@
// ----------------------------------------------------------------------------
// va2f_lane
// Converts one raw component to single float bits: double rounding, float
// pass-through, integer to float, division by 2^n-1 via a repeated shifted
// sum (2^n for 32-bit kinds). Eight register stages, all advanced by adv.
// ----------------------------------------------------------------------------
module va2f_lane (
  input  logic                  clk,
  input  logic                  adv,
  input  va2f_pkg::elem_type_t  etype,
  input  va2f_pkg::raw_t        raw,
  output va2f_pkg::f32_t        result
);
  import va2f_pkg::*;

  typedef struct packed {
    logic       direct;
    f32_t       dbits;
    logic       neg;
    logic [5:0] n;
    logic       sum;
    logic       zero;
    logic [5:0] expo;
  } side_t;

  // double to single, round to nearest even
  function automatic f32_t f64_to_f32(raw_t b);
    logic               sgn;
    logic [10:0]        ex;
    logic signed [12:0] fe;
    logic [63:0]        mm;
    logic [63:0]        q;
    logic [63:0]        lowmask;
    logic [6:0]         sh;
    logic               g;
    logic               st;
    logic [30:0]        mag;
    f32_t               r;
    sgn = b[63];
    ex  = b[62:52];
    fe  = $signed({2'b00, ex}) - 13'sd896;
    mm  = {11'd0, 1'b1, b[51:0]};
    sh  = (fe >= 13'sd1) ? 7'd29 : 7'(13'sd30 - fe);
    q       = mm >> sh;
    g       = mm[6'(sh - 7'd1)];
    lowmask = (64'd1 << (sh - 7'd1)) - 64'd1;
    st      = |(mm & lowmask);
    if (g && (st || q[0])) q = q + 64'd1;
    mag = 31'({fe[7:0] - 8'd1, 23'd0}) + q[30:0];
    if (ex == 11'h7FF) begin
      if (b[51:0] != 52'd0) r = {sgn, 8'hFF, 1'b1, b[50:29]};
      else r = {sgn, 8'hFF, 23'd0};
    end else if (ex == 11'd0) begin
      r = {sgn, 31'd0};
    end else if (fe >= 13'sd255) begin
      r = {sgn, 8'hFF, 23'd0};
    end else if (fe >= 13'sd1) begin
      r = {sgn, mag};
    end else if (fe < -13'sd30) begin
      r = {sgn, 31'd0};
    end else begin
      r = {sgn, q[30:0]};
    end
    return r;
  endfunction

  // one step of x * (1 + 2^-n)(1 + 2^-2n)...
  function automatic logic [64:0] rep_add(logic [64:0] a, logic [5:0] n, logic [1:0] k,
                                          logic en);
    logic [8:0] sh;
    sh = 9'(n) << k;
    return en ? a + (a >> sh) : a;
  endfunction

  // stage 1 decode
  side_t       sd1_next;
  logic [31:0] mag_next;
  f32_t        d64;

  assign d64 = f64_to_f32(raw);

  always_comb begin
    sd1_next        = '0;
    sd1_next.dbits  = d64;
    mag_next        = 32'd0;
    unique case (etype)
      ET_F64: sd1_next.direct = 1'b1;
      ET_F32: begin
        sd1_next.direct = 1'b1;
        sd1_next.dbits  = raw[31:0];
      end
      ET_U32S: mag_next = raw[31:0];
      ET_U32N: begin
        mag_next   = raw[31:0];
        sd1_next.n = 6'd32;
      end
      ET_S32S, ET_S32N: begin
        sd1_next.neg = raw[31];
        mag_next     = raw[31] ? ~raw[31:0] + 32'd1 : raw[31:0];
        if (etype == ET_S32N) sd1_next.n = 6'd31;
      end
      ET_U16S, ET_U16N: begin
        mag_next = {16'd0, raw[15:0]};
        if (etype == ET_U16N) begin
          sd1_next.n   = 6'd16;
          sd1_next.sum = 1'b1;
        end
      end
      ET_S16S, ET_S16N: begin
        sd1_next.neg = raw[15];
        mag_next     = {16'd0, raw[15] ? ~raw[15:0] + 16'd1 : raw[15:0]};
        if (etype == ET_S16N) begin
          sd1_next.n   = 6'd15;
          sd1_next.sum = 1'b1;
        end
      end
      ET_U8S, ET_U8N: begin
        mag_next = {24'd0, raw[7:0]};
        if (etype == ET_U8N) begin
          sd1_next.n   = 6'd8;
          sd1_next.sum = 1'b1;
        end
      end
      ET_S8S, ET_S8N: begin
        sd1_next.neg = raw[7];
        mag_next     = {24'd0, raw[7] ? ~raw[7:0] + 8'd1 : raw[7:0]};
        if (etype == ET_S8N) begin
          sd1_next.n   = 6'd7;
          sd1_next.sum = 1'b1;
        end
      end
      default: sd1_next.direct = 1'b1;
    endcase
  end

  side_t       sd [1:7];
  logic [31:0] mag1;
  logic [31:0] norm2;
  logic [23:0] sig3;
  logic [64:0] acc [1:4];

  // stage 2 normalize, five binary steps
  logic [31:0] nm;
  logic [4:0]  lz;
  always_comb begin
    nm = mag1;
    lz = 5'd0;
    if (nm[31:16] == 16'd0) begin nm = nm << 16; lz[4] = 1'b1; end
    if (nm[31:24] == 8'd0)  begin nm = nm << 8;  lz[3] = 1'b1; end
    if (nm[31:28] == 4'd0)  begin nm = nm << 4;  lz[2] = 1'b1; end
    if (nm[31:30] == 2'd0)  begin nm = nm << 2;  lz[1] = 1'b1; end
    if (nm[31] == 1'b0)     begin nm = nm << 1;  lz[0] = 1'b1; end
  end

  // stage 3 round to 24 bits
  logic [24:0] rsum;
  logic        rup;
  assign rup  = norm2[7] & ((|norm2[6:0]) | norm2[8]);
  assign rsum = {1'b0, norm2[31:8]} + 25'(rup);

  // side info for stages 2 and 3
  side_t sd2_next;
  side_t sd3_next;
  always_comb begin
    sd2_next      = sd[1];
    sd2_next.zero = (mag1 == 32'd0);
    sd2_next.expo = 6'd31 - 6'(lz);
    sd3_next      = sd[2];
    sd3_next.expo = sd[2].expo + 6'(rsum[24]);
  end

  // stage 8 final round and pack
  logic        hi;
  logic [23:0] sig_t;
  logic        gbit;
  logic [24:0] fsum;
  logic [9:0]  bexp;
  f32_t        packed_bits;
  always_comb begin
    hi    = acc[4][64];
    sig_t = hi ? acc[4][64:41] : acc[4][63:40];
    gbit  = hi ? acc[4][40] : acc[4][39];
    fsum  = {1'b0, sig_t} + 25'(gbit);
    bexp  = 10'(sd[7].expo) - 10'(sd[7].n) + 10'd127 + 10'(hi) + 10'(fsum[24]);
    packed_bits = {sd[7].neg, bexp[7:0], fsum[22:0]};
    if (sd[7].direct) packed_bits = sd[7].dbits;
    else if (sd[7].zero) packed_bits = ZERO_BITS;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[1] <= sd1_next;
      mag1  <= mag_next;

      sd[2] <= sd2_next;
      norm2 <= nm;

      sd[3] <= sd3_next;
      sig3  <= rsum[24] ? 24'h800000 : rsum[23:0];

      sd[4]  <= sd[3];
      acc[1] <= rep_add({1'b0, sig3, 40'd0}, sd[3].n, 2'd0, sd[3].sum);
      for (int k = 1; k < 4; k++) begin
        sd[k+4]  <= sd[k+3];
        acc[k+1] <= rep_add(acc[k], sd[k+3].n, 2'(k), sd[k+3].sum);
      end

      result <= packed_bits;
    end
  end

endmodule

@@ rtl/va2f_merge.sv @@
// ----------------------------------------------------------------------------
// va2f_merge
// Combines the four lane results into the output word, filling missing
// components with 0,0,0,1.
// ----------------------------------------------------------------------------
module va2f_merge (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic [va2f_pkg::NUM_LANES-1:0]       present,
  input  va2f_pkg::f32_t                       lane_res [va2f_pkg::NUM_LANES],
  output va2f_pkg::f32_t                       out_x,
  output va2f_pkg::f32_t                       out_y,
  output va2f_pkg::f32_t                       out_z,
  output va2f_pkg::f32_t                       out_w
);
  import va2f_pkg::*;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= present[0] ? lane_res[0] : ZERO_BITS;
      out_y <= present[1] ? lane_res[1] : ZERO_BITS;
      out_z <= present[2] ? lane_res[2] : ZERO_BITS;
      out_w <= present[3] ? lane_res[3] : ONE_BITS;
    end
  end

endmodule
